// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] key;
    logic [31:0] priority_req;
    logic [31:0] cost;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_key;
    logic [31:0] out_priority;
    logic [31:0] out_cost;
    logic [8:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] prio;
    logic [31:0] cost;
  } slot_t;

  localparam logic       KIND_INSERT = 1'b0;
  localparam logic       KIND_POP    = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_LOWERED  = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_POPPED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

endpackage

// File: rtl/mhpq_ram.sv
module mhpq_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/min_heap_priority_queue_top.sv
// Insert: linear key search over the stored entries, then sift-up one heap level at a time
// (S_UP_RD, S_UP_CMP). Pop: read the root, then the last entry, then sift-down level by level.
// One item at a time; the entry RAM has one read port and one separate write port.
// The next item is taken while a result still waits in the output register.
// Synchronous reset empties the queue; the entry RAM is not cleared and holds no valid bits.
module min_heap_priority_queue_top #(
  parameter int CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mhpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mhpq_pkg::rsp_t rsp
);

  import mhpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SEARCH   = 4'd1;
  localparam logic [3:0] S_APPEND   = 4'd2;
  localparam logic [3:0] S_UP_RD    = 4'd3;
  localparam logic [3:0] S_UP_CMP   = 4'd4;
  localparam logic [3:0] S_POP_RD0  = 4'd5;
  localparam logic [3:0] S_POP_RDL  = 4'd6;
  localparam logic [3:0] S_POP_LAST = 4'd7;
  localparam logic [3:0] S_DN_RDL   = 4'd8;
  localparam logic [3:0] S_DN_RDR   = 4'd9;
  localparam logic [3:0] S_DN_CMP   = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]    state;
  logic [CW-1:0] count;
  req_t          cur;
  slot_t         ent;
  slot_t         child;
  logic [IW-1:0] idx;
  logic [CW-1:0] scan;
  logic          cmp_pend;
  logic [IW-1:0] cmp_addr;
  logic          right_ok;
  logic [2:0]    res_status;
  logic [15:0]   res_key;
  logic [31:0]   res_prio;
  logic [31:0]   res_cost;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  slot_t         rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;

  logic [IW-1:0] parent;
  logic [CW:0]   left_w;
  logic [CW:0]   right_w;
  logic [IW-1:0] last_w;
  logic          rd_hit;
  logic          scan_end;
  logic          pick_right;
  slot_t         pick;
  logic [IW-1:0] pick_idx;
  slot_t         new_ent;

  assign parent     = IW'((idx - IW'(1)) >> 1);
  assign left_w     = (CW+1)'({idx, 1'b1});
  assign right_w    = left_w + (CW+1)'(1);
  assign last_w     = IW'(count - CW'(1));
  assign rd_hit     = cmp_pend && (rd_data.key == cur.key);
  assign scan_end   = cmp_pend && ((CW'(cmp_addr)) == (count - CW'(1)));
  assign pick_right = right_ok && (rd_data.prio < child.prio);
  assign pick       = pick_right ? rd_data : child;
  assign pick_idx   = pick_right ? IW'(right_w) : IW'(left_w);
  assign new_ent    = '{key: cur.key, prio: cur.priority_req, cost: cur.cost};
  assign req_ready  = (state == S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = ent;
    case (state)
      S_SEARCH: begin
        if (!rd_hit && !scan_end && (scan < count)) begin
          rd_en   = 1'b1;
          rd_addr = IW'(scan);
        end
      end
      S_UP_RD: begin
        if (idx == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_data.prio > ent.prio) begin
          wr_data = rd_data;
        end
      end
      S_POP_RD0: begin
        rd_en = 1'b1;
      end
      S_POP_RDL: begin
        rd_en   = 1'b1;
        rd_addr = last_w;
      end
      S_DN_RDL: begin
        if (left_w >= (CW+1)'(count)) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(left_w);
        end
      end
      S_DN_RDR: begin
        if (right_w < (CW+1)'(count)) begin
          rd_en   = 1'b1;
          rd_addr = IW'(right_w);
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (ent.prio > pick.prio) begin
          wr_data = pick;
        end
      end
      default: begin
      end
    endcase
  end

  mhpq_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      cmp_pend  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur      <= req;
            res_key  <= '0;
            res_prio <= '0;
            res_cost <= '0;
            cmp_pend <= 1'b0;
            scan     <= '0;
            if (req.kind == KIND_POP) begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_POP_RD0;
              end
            end else if (count == '0) begin
              state <= S_APPEND;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (rd_hit) begin
            if (cur.priority_req < rd_data.prio) begin
              ent        <= new_ent;
              idx        <= cmp_addr;
              res_status <= ST_LOWERED;
              state      <= S_UP_RD;
            end else begin
              res_status <= ST_IGNORED;
              state      <= S_DONE;
            end
          end else if (scan_end) begin
            state <= S_APPEND;
          end else if (scan < count) begin
            cmp_pend <= 1'b1;
            cmp_addr <= IW'(scan);
            scan     <= scan + CW'(1);
          end
        end
        S_APPEND: begin
          if (count == CW'(CAPACITY)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            ent        <= new_ent;
            idx        <= IW'(count);
            count      <= count + CW'(1);
            res_status <= ST_INSERTED;
            state      <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          state <= (idx == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (rd_data.prio > ent.prio) begin
            idx   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_RD0: begin
          state <= S_POP_RDL;
        end
        S_POP_RDL: begin
          res_key  <= rd_data.key;
          res_prio <= rd_data.prio;
          res_cost <= rd_data.cost;
          state    <= S_POP_LAST;
        end
        S_POP_LAST: begin
          ent        <= rd_data;
          count      <= count - CW'(1);
          idx        <= '0;
          res_status <= ST_POPPED;
          state      <= S_DN_RDL;
        end
        S_DN_RDL: begin
          state <= (left_w >= (CW+1)'(count)) ? S_DONE : S_DN_RDR;
        end
        S_DN_RDR: begin
          child    <= rd_data;
          right_ok <= (right_w < (CW+1)'(count));
          state    <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (ent.prio > pick.prio) begin
            idx   <= pick_idx;
            state <= S_DN_RDL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: res_status, out_key: res_key, out_priority: res_prio,
                           out_cost: res_cost, occupancy: 9'(count)};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mhpq_checker.sv
module mhpq_props (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input mhpq_pkg::rsp_t rsp
);

  import mhpq_pkg::*;

  // stalled item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("block ready straight after accepting an item");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_POPPED) |->
      (rsp.out_key == '0) && (rsp.out_priority == '0) && (rsp.out_cost == '0))
    else $error("non-pop result carries entry data");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
    else $error("empty pop with non-zero occupancy");

endmodule

bind min_heap_priority_queue_top mhpq_props u_mhpq_props (.*);

// File: verif/mhpq_checker.sv
module mhpq_checker #(
  parameter int CAPACITY = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  mhpq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  mhpq_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  logic [15:0] heap_key  [CAPACITY];
  logic [31:0] heap_prio [CAPACITY];
  logic [31:0] heap_cost [CAPACITY];
  int unsigned heap_size;
  rsp_t        owed_rsp[$];
  int          fail_count;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [15:0] k;
    logic [31:0] p;
    logic [31:0] c;
    k = heap_key[a];
    p = heap_prio[a];
    c = heap_cost[a];
    heap_key[a]  = heap_key[b];
    heap_prio[a] = heap_prio[b];
    heap_cost[a] = heap_cost[b];
    heap_key[b]  = k;
    heap_prio[b] = p;
    heap_cost[b] = c;
  endfunction

  function automatic void sift_up(int unsigned idx);
    int unsigned parent;
    while (idx > 0) begin
      parent = (idx - 1) / 2;
      if (heap_prio[parent] > heap_prio[idx]) begin
        swap_slots(parent, idx);
        idx = parent;
      end else begin
        break;
      end
    end
  endfunction

  // ties keep the left child
  function automatic void sift_down(int unsigned idx);
    int unsigned left;
    int unsigned pick;
    while (idx < heap_size) begin
      left = 2 * idx + 1;
      if (left >= heap_size) break;
      pick = left;
      if (left + 1 < heap_size && heap_prio[left + 1] < heap_prio[left]) pick = left + 1;
      if (heap_prio[idx] > heap_prio[pick]) begin
        swap_slots(idx, pick);
        idx = pick;
      end else begin
        break;
      end
    end
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t        res;
    int unsigned hit;
    int unsigned last;
    bit          found;
    res   = '0;
    found = 1'b0;
    hit   = 0;
    if (r.kind == KIND_INSERT) begin
      for (int unsigned i = 0; i < heap_size; i++) begin
        if (heap_key[i] == r.key) begin
          found = 1'b1;
          hit   = i;
          break;
        end
      end
      if (found) begin
        if (r.priority_req < heap_prio[hit]) begin
          heap_prio[hit] = r.priority_req;
          heap_cost[hit] = r.cost;
          sift_up(hit);
          res.status = ST_LOWERED;
        end else begin
          res.status = ST_IGNORED;
        end
      end else if (heap_size >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        heap_key[heap_size]  = r.key;
        heap_prio[heap_size] = r.priority_req;
        heap_cost[heap_size] = r.cost;
        heap_size++;
        sift_up(heap_size - 1);
        res.status = ST_INSERTED;
      end
    end else if (heap_size == 0) begin
      res.status = ST_EMPTY;
    end else begin
      last = heap_size - 1;
      swap_slots(0, last);
      res.out_key      = heap_key[last];
      res.out_priority = heap_prio[last];
      res.out_cost     = heap_cost[last];
      heap_size        = last;
      sift_down(0);
      res.status = ST_POPPED;
    end
    res.occupancy = 9'(heap_size);
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      heap_size = 0;
      owed_rsp.delete();
    end else begin
      if (req_valid && req_ready) owed_rsp.push_back(heap_apply(req));
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp.size() == 0) begin
          report("item with no result owed", 32'(rsp.status), 32'(rsp.occupancy));
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.status !== want.status)
            report("status", 32'(rsp.status), 32'(want.status));
          if (rsp.out_key !== want.out_key)
            report("out_key", 32'(rsp.out_key), 32'(want.out_key));
          if (rsp.out_priority !== want.out_priority)
            report("out_priority", rsp.out_priority, want.out_priority);
          if (rsp.out_cost !== want.out_cost) report("out_cost", rsp.out_cost, want.out_cost);
          if (rsp.occupancy !== want.occupancy)
            report("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
        end
      end
    end
    pending <= owed_rsp.size();
    errors  <= fail_count;
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int LIMIT      = 2_000_000;
  localparam int LONG_HOLD  = 3000;
  localparam int DRAIN_WAIT = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int errors;
  int pending;
  int cycles     = 0;
  bit hold_go    = 1'b0;
  bit hold_done  = 1'b0;
  bit offering   = 1'b0;
  int burst_left = 0;

  always #2 clk = ~clk;

  min_heap_priority_queue_top dut (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp
  );

  mhpq_checker chk (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp,
    .errors,
    .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic req_t make_req(logic kind, logic [15:0] key, logic [31:0] prio,
                                    logic [31:0] cost);
    req_t r;
    r.kind         = kind;
    r.key          = key;
    r.priority_req = prio;
    r.cost         = cost;
    return r;
  endfunction

  // small key pool for repeats, top-bit priorities for ties
  function automatic req_t mixed_req();
    logic [15:0] key;
    logic [31:0] prio;
    int          pick;
    pick = $urandom_range(0, 9);
    key  = (pick < 7) ? 16'($urandom_range(0, 31)) : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 4)       prio = {3'($urandom_range(0, 7)), 29'd0};
    else if (pick == 4) prio = 32'h0;
    else if (pick == 5) prio = 32'hFFFF_FFFF;
    else                prio = $urandom;
    return make_req(($urandom_range(0, 9) < 4) ? KIND_POP : KIND_INSERT, key, prio, $urandom);
  endfunction

  task automatic go_idle();
    if (offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_item(req_t r);
    int gap;
    req       <= r;
    req_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!req_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 9);
      gap = $urandom_range(1, 12);
      go_idle();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    go_idle();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_mix(int n);
    repeat (n) send_item(mixed_req());
  endtask

  initial begin
    int ready_pct;
    int span;
    forever begin
      ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(15, 95);
      span      = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        if (hold_go && !hold_done) begin
          rsp_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_done = 1'b1;
          rsp_ready <= 1'b1;
        end else begin
          rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
      end
    end
  end

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(make_req(KIND_POP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(KIND_INSERT, 16'h0000, 32'h0000_0000, 32'h0000_0000));
    send_item(make_req(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(KIND_INSERT, 16'h1234, 32'h8000_0000, 32'hA5A5_A5A5));
    send_item(make_req(KIND_INSERT, 16'h1234, 32'h8000_0000, 32'h1111_1111));
    send_item(make_req(KIND_INSERT, 16'h1234, 32'h9000_0000, 32'h3333_3333));
    send_item(make_req(KIND_INSERT, 16'h1234, 32'h0000_0001, 32'h2222_2222));
    send_item(make_req(KIND_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 32'h5A5A_5A5A));
    send_item(make_req(KIND_INSERT, 16'h0001, 32'h8000_0000, 32'h0000_0001));
    send_item(make_req(KIND_INSERT, 16'h0002, 32'h8000_0000, 32'h0000_0002));
    send_item(make_req(KIND_INSERT, 16'h0003, 32'h8000_0000, 32'h0000_0003));
    send_item(make_req(KIND_INSERT, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF));
    repeat (7) send_item(make_req(KIND_POP, 16'($urandom), $urandom, $urandom));

    // receiver holds off while items keep coming
    hold_go <= 1'b1;
    run_mix(200);

    // fill past capacity, then lower, ignore and reject while full, then drain
    wait_drained();
    for (i = 0; i < 300; i++) begin
      send_item(make_req(KIND_INSERT, 16'h8000 + 16'(i), {1'b1, 31'($urandom)}, $urandom));
    end
    for (i = 0; i < 40; i++) begin
      case ($urandom_range(0, 3))
        0, 1: send_item(make_req(KIND_INSERT, 16'h8000 + 16'($urandom_range(0, 299)),
                                 {1'b0, 31'($urandom)}, $urandom));
        2: send_item(make_req(KIND_INSERT, 16'h9000 + 16'(i), $urandom, $urandom));
        default: send_item(make_req(KIND_INSERT, 16'h8000 + 16'($urandom_range(0, 299)),
                                    32'hFFFF_FFFF, $urandom));
      endcase
    end
    repeat (300) send_item(make_req(KIND_POP, 16'($urandom), $urandom, $urandom));

    run_mix(210);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/min_heap_priority_queue_top.sv
rtl/mhpq_checker.sv
verif/mhpq_checker.sv
verif/tb.sv
